// ===== rtl/core/mcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcd_pkg
// Constants and code table for the Morse code decoder.
// ----------------------------------------------------------------------------
package mcd_pkg;

   localparam int MaxSymbolsDefault = 6;

   // Longest code held in the table
   localparam int CodeWidth = 5;
   localparam int IndexWidth = CodeWidth + 1;

   localparam logic [7:0] CharHash  = 8'h23;
   localparam logic [7:0] CharSlash = 8'h2F;
   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharNone  = 8'h00;

   // Index is a leading marker one followed by the code, first symbol MSB,
   // dash = 1. Returns CharNone for codes outside the table.
   function automatic logic [7:0] code_lookup(input logic [IndexWidth-1:0] index);
      logic [7:0] c;
      unique case (index)
         6'd2:    c = "E";
         6'd3:    c = "T";
         6'd4:    c = "I";
         6'd5:    c = "A";
         6'd6:    c = "N";
         6'd7:    c = "M";
         6'd8:    c = "S";
         6'd9:    c = "U";
         6'd10:   c = "R";
         6'd11:   c = "W";
         6'd12:   c = "D";
         6'd13:   c = "K";
         6'd14:   c = "G";
         6'd15:   c = "O";
         6'd16:   c = "H";
         6'd17:   c = "V";
         6'd18:   c = "F";
         6'd20:   c = "L";
         6'd22:   c = "P";
         6'd23:   c = "J";
         6'd24:   c = "B";
         6'd25:   c = "X";
         6'd26:   c = "C";
         6'd27:   c = "Y";
         6'd28:   c = "Z";
         6'd29:   c = "Q";
         6'd32:   c = "5";
         6'd33:   c = "4";
         6'd35:   c = "3";
         6'd39:   c = "2";
         6'd40:   c = "&";
         6'd42:   c = "+";
         6'd47:   c = "1";
         6'd48:   c = "6";
         6'd49:   c = "=";
         6'd50:   c = "/";
         6'd54:   c = "(";
         6'd56:   c = "7";
         6'd60:   c = "8";
         6'd62:   c = "9";
         6'd63:   c = "0";
         default: c = CharNone;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/morse_code_decoder_top.sv =====
// ----------------------------------------------------------------------------
// morse_code_decoder_top
// Collects dots and dashes from a byte stream and decodes them to ASCII.
// ----------------------------------------------------------------------------
//
//   channel   direction  ports                                  role
//   req_      in         req_symbol[7:0], req_end_of_input      text byte / flush
//   rsp_      out        rsp_character[7:0]                     decoded character
//
// One byte is taken every cycle unless the result register is held full.
// The pending-code update and the table lookup are combinational logic in
// front of the result register, so a decoded character appears in the
// cycle after the byte that ends it. The result register is the only buffer:
// a new byte is taken whenever it is empty or being drained in the same
// cycle. Synchronous reset clears the pending code and the result valid flag.
//
module morse_code_decoder_top #(
   parameter int MAX_SYMBOLS = mcd_pkg::MaxSymbolsDefault
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_input,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_character
);

   import mcd_pkg::*;

   localparam int CountWidth = $clog2(MAX_SYMBOLS + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(MAX_SYMBOLS);
   localparam logic [CountWidth-1:0] CountMaxCode = CountWidth'(CodeWidth);

   // Pending code state
   logic [CodeWidth-1:0]  code_ff, code_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  invalid_ff, invalid_in;
   logic                  slash_first_ff, slash_first_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;

   logic                  accept;
   logic                  is_dot, is_dash, is_slash, is_space;
   logic [IndexWidth-1:0] table_index;
   logic [7:0]            table_char;
   logic [7:0]            decoded;

   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;

   assign is_dot   = (req_symbol == CharDot);
   assign is_dash  = (req_symbol == CharDash);
   assign is_slash = (req_symbol == CharSlash);
   assign is_space = (req_symbol == CharSpace);

   // Marker one above the code; upper code bits stay zero for short codes
   assign table_index = (IndexWidth'(1) << count_ff) | {1'b0, code_ff};
   assign table_char  = code_lookup(table_index);

   // Decode of whatever is pending now
   always_comb begin
      if (invalid_ff) begin
         decoded = CharHash;
      end else if (slash_first_ff) begin
         decoded = (count_ff == CountWidth'(1)) ? CharSpace : CharHash;
      end else if (count_ff != '0 && count_ff <= CountMaxCode && table_char != CharNone) begin
         decoded = table_char;
      end else begin
         decoded = CharHash;
      end
   end

   always_comb begin
      code_in        = code_ff;
      count_in       = count_ff;
      invalid_in     = invalid_ff;
      slash_first_in = slash_first_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_char_in    = rsp_char_ff;

      if (accept) begin
         if (req_end_of_input || count_ff >= CountFull || is_space) begin
            // Flush: emit one character and clear the pending code.
            // A full buffer gives '#' whatever the byte is.
            rsp_valid_in   = 1'b1;
            rsp_char_in    = (!req_end_of_input && count_ff >= CountFull) ? CharHash
                                                                          : decoded;
            code_in        = '0;
            count_in       = '0;
            invalid_in     = 1'b0;
            slash_first_in = 1'b0;
         end else begin
            if (is_slash) begin
               if (count_ff == '0) begin
                  slash_first_in = 1'b1;
               end else begin
                  invalid_in = 1'b1;
               end
            end else if (!is_dot && !is_dash) begin
               invalid_in = 1'b1;
            end
            code_in  = {code_ff[CodeWidth-2:0], is_dash};
            count_in = count_ff + CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff        <= '0;
         count_ff       <= '0;
         invalid_ff     <= 1'b0;
         slash_first_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         code_ff        <= code_in;
         count_ff       <= count_in;
         invalid_ff     <= invalid_in;
         slash_first_ff <= slash_first_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
   end

endmodule

// ===== test/morse_code_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// morse_code_decoder_top_tb
// Self-checking bench for the Morse code decoder: a directed pass over the
// empty, slash, malformed and overflow cases, then random dot/dash words
// with noise, checked character by character against an in-bench predictor.
// ----------------------------------------------------------------------------

// Tracks the pending code as bytes are accepted and queues the characters
// the block must produce, in order.
class morse_char_scoreboard;

   // Morse tree in heap order: index = leading one, then the code (dash = 1)
   string code_tree = "##ETIANMSURWDKGOHVF#L#PJBXCYZQ##54#3###2&#+####16=/###(#7###8#90";

   logic [5:0]  code_q;
   int unsigned sym_count;
   bit          bad_seen;
   bit          lead_slash;

   logic [7:0]  chars_due[$];
   int unsigned failures;

   function void clear_code();
      code_q     = '0;
      sym_count  = 0;
      bad_seen   = 1'b0;
      lead_slash = 1'b0;
   endfunction

   function logic [7:0] char_of_pending();
      logic [5:0] idx;
      if (bad_seen)
         return mcd_pkg::CharHash;
      if (lead_slash)
         return (sym_count == 1) ? mcd_pkg::CharSpace : mcd_pkg::CharHash;
      if (sym_count >= 1 && sym_count <= 5) begin
         idx = 6'(1 << sym_count) | {1'b0, code_q[4:0]};
         return code_tree[idx];
      end
      return mcd_pkg::CharHash;
   endfunction

   function void note_byte(logic [7:0] sym, logic eoi);
      if (eoi) begin
         chars_due.push_back(char_of_pending());
         clear_code();
      end else if (sym_count >= mcd_pkg::MaxSymbolsDefault) begin
         // full code: byte is dropped, whatever it is
         chars_due.push_back(mcd_pkg::CharHash);
         clear_code();
      end else if (sym == mcd_pkg::CharSpace) begin
         chars_due.push_back(char_of_pending());
         clear_code();
      end else begin
         if (sym == mcd_pkg::CharSlash) begin
            if (sym_count == 0)
               lead_slash = 1'b1;
            else
               bad_seen = 1'b1;
         end else if (sym != mcd_pkg::CharDot && sym != mcd_pkg::CharDash) begin
            bad_seen = 1'b1;
         end
         code_q    = {code_q[4:0], sym == mcd_pkg::CharDash};
         sym_count = sym_count + 1;
      end
   endfunction

   function void check_char(logic [7:0] actual);
      logic [7:0] due;
      if (chars_due.size() == 0) begin
         $error("character: none expected, got 0x%02h", actual);
         failures++;
         return;
      end
      due = chars_due.pop_front();
      if (actual !== due) begin
         $error("character: expected 0x%02h, got 0x%02h", due, actual);
         failures++;
      end
   endfunction

   function int unsigned pending();
      return chars_due.size();
   endfunction

endclass

module morse_code_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcd_pkg::*;

   localparam int ItemTarget = 1100;
   localparam int CalmTail   = 150;    // last items run with no idling
   localparam int HoldCycles = 80;     // long receiver hold-off
   localparam int CycleLimit = 300000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_symbol = '0;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_character;

   morse_char_scoreboard char_board = new();

   int unsigned items_sent = 0;
   int unsigned cycles = 0;
   bit          idle_on = 1'b1;    // random gaps / stalls enabled
   bit          hold_rsp = 1'b0;   // request for a long receiver hold-off

   morse_code_decoder_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_symbol      (req_symbol),
      .req_end_of_input(req_end_of_input),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_character   (rsp_character)
   );

   always #6 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Monitors sample at the edge, before any of this edge's updates land.
   // A result is registered, so it is always noted before it can show.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         char_board.note_byte(req_symbol, req_end_of_input);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         char_board.check_char(rsp_character);
   end

   // Receiver: ready bursts and stall bursts, plus one long hold-off on request.
   // Each pass waits for a clock edge, so rsp_ready gets one update per step.
   initial begin
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // One transfer on the request side. Returns at the accepting edge, so the
   // next call makes the only assignment to req_valid in that step.
   task automatic send_byte(input logic [7:0] sym, input logic eoi);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_symbol       <= sym;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Space most of the time, end marker with a random (ignored) byte otherwise
   task automatic send_terminator();
      if ($urandom_range(0, 6) == 0)
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      else
         send_byte(CharSpace, 1'b0);
   endtask

   // One random word: mostly well-formed dot/dash codes of table length,
   // some lone slashes, some over-long codes, some with stray bytes mixed in,
   // and a little raw noise.
   task automatic send_random_word();
      int         kind;
      int         len;
      logic [7:0] sym;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         send_byte(CharSlash, 1'b0);
         send_terminator();
      end else if (kind < 95) begin
         len = (kind < 85) ? $urandom_range(1, 5) : $urandom_range(6, 8);
         for (int i = 0; i < len; i++) begin
            sym = $urandom_range(0, 1) ? CharDash : CharDot;
            if (kind >= 70 && $urandom_range(0, 3) == 0)
               sym = $urandom_range(0, 1) ? CharSlash : 8'($urandom_range(0, 255));
            send_byte(sym, 1'b0);
         end
         send_terminator();
      end else begin
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Stop offering and let every expected character come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (char_board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      // Directed words; a newline marks an end-marker transfer:
      //   end and space with nothing pending, a plain letter, a lone slash,
      //   slash followed by a dot, slash after a dash plus a stray byte,
      //   six dashes then a space (overflow, space dropped),
      //   six symbols closed by the end marker.
      string       directed;
      bit          hold_done;
      bit          drain_done;
      logic [7:0]  flush_sym;
      directed   = "\n .- / /.\n-/x ------ .....-\n";
      hold_done  = 1'b0;
      drain_done = 1'b0;
      flush_sym  = 8'hFF;

      char_board.clear_code();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < directed.len(); i++) begin
         if (directed[i] == 8'h0A) begin
            // symbol is ignored here; alternate all-ones / all-zeros bytes
            send_byte(flush_sym, 1'b1);
            flush_sym = ~flush_sym;
         end else begin
            send_byte(directed[i], 1'b0);
         end
      end

      while (items_sent < ItemTarget) begin
         if (!hold_done && items_sent >= 400) begin
            // receiver sits out a long stretch while words keep coming,
            // so the result register fills and the request side stalls
            hold_rsp  = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && items_sent >= 700) begin
            wait_drained();
            drain_done = 1'b1;
         end
         if (items_sent >= ItemTarget - CalmTail)
            idle_on = 1'b0;
         send_random_word();
      end

      wait_drained();
      repeat (8) @(posedge clock);

      if (char_board.failures == 0 && char_board.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mcd_pkg.sv
rtl/core/morse_code_decoder_top.sv
test/morse_code_decoder_top_tb.sv
